[hdl/orl_pkg.sv]
// Package for the overwrite ring log: sizes, command codes and the
// control/status structs between the controller and the datapath.
// No dependencies.
package orl_pkg;

   localparam int CAPACITY      = 8192;
   localparam int SLOT_W        = $clog2(CAPACITY);
   localparam int COUNT_W       = SLOT_W + 1;
   localparam int MAX_BATCH     = 64;
   localparam int BATCH_W       = $clog2(MAX_BATCH + 1);
   localparam int STAMP_W       = 63;
   localparam int WORD_W        = 32;
   localparam int AGE_W         = 32;
   localparam int ENTRY_W       = STAMP_W + 2 * WORD_W;
   localparam int US_PER_SECOND = 1000000;

   // One million is 64 times 15625: the power of two is a shift, the odd
   // factor is a multiply by its rounded-up reciprocal scaled by 2^60
   localparam int AGE_SHIFT     = 6;
   localparam int AGE_ODD_DIV   = US_PER_SECOND >> AGE_SHIFT;
   localparam int RECIP_SHIFT   = 60;
   localparam int RECIP_W       = 47;
   localparam logic [RECIP_W-1:0] AGE_RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(AGE_ODD_DIV) + 64'd1);

   // Multiply in chunks of the shifted dividend, one chunk per cycle
   localparam int DIV_CHUNK_W   = 12;
   localparam int DIV_ITERS     = 4;
   localparam int DIV_Y_W       = DIV_CHUNK_W * DIV_ITERS;
   localparam int DIV_PROD_W    = DIV_CHUNK_W + RECIP_W;
   localparam int DIV_ACC_W     = DIV_PROD_W + 1;
   localparam int AGE_POS       = RECIP_SHIFT - (DIV_ITERS - 1) * DIV_CHUNK_W;
   localparam int DIV_CNT_W     = $clog2(DIV_ITERS + 1);

   // Smallest elapsed time whose age no longer fits in AGE_W bits
   localparam logic [STAMP_W-1:0] AGE_SAT_LIMIT = STAMP_W'(US_PER_SECOND) << AGE_W;

   typedef enum logic [1:0] {
      CMD_APPEND  = 2'd0,
      CMD_PEEK    = 2'd1,
      CMD_ADVANCE = 2'd2
   } orl_op_type;

   typedef struct packed {
      logic capture;    // load request fields
      logic exec;       // run append / advance / peek setup
      logic mem_rd;     // read record at current peek index
      logic diff;       // form elapsed time of read record
      logic div_start;  // launch age divider
      logic out_rec;    // load output with a record
      logic out_plain;  // load output with an empty result
      logic next_rec;   // advance peek index
   } orl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       batch_zero;
      logic       div_busy;
      logic       out_last;
   } orl_status_type;

endpackage

[hdl/orl_age_div.sv]
// Divider that turns elapsed microseconds into whole seconds by a reciprocal
// multiply over the chunks of the dividend, with zero floor and 32-bit saturation.
// Depends on orl_pkg.
module orl_age_div
   import orl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               nonpos,
   input  logic [STAMP_W-1:0] elapsed,
   output logic               busy,
   output logic [AGE_W-1:0]   age
);

   logic [DIV_ACC_W-1:0]  acc_ff, acc_in;
   logic [DIV_Y_W-1:0]    y_ff;
   logic [DIV_PROD_W-1:0] partial;
   logic [DIV_CNT_W-1:0]  count_ff;
   logic                  busy_ff;
   logic [AGE_W-1:0]      age_ff;

   // Low chunk first; drop the sum bits that can no longer reach the quotient
   assign partial = DIV_PROD_W'(y_ff[DIV_CHUNK_W-1:0]) * DIV_PROD_W'(AGE_RECIP);
   assign acc_in  = (acc_ff >> DIV_CHUNK_W) + DIV_ACC_W'(partial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         if (nonpos || elapsed >= AGE_SAT_LIMIT) begin
            busy_ff <= 1'b0;
         end else begin
            busy_ff  <= 1'b1;
            count_ff <= DIV_CNT_W'(DIV_ITERS);
         end
      end else if (busy_ff) begin
         count_ff <= count_ff - DIV_CNT_W'(1);
         busy_ff  <= (count_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         if (nonpos) begin
            age_ff <= '0;
         end else if (elapsed >= AGE_SAT_LIMIT) begin
            age_ff <= '1;
         end else begin
            // Below the limit the shifted dividend fits in DIV_Y_W bits
            acc_ff <= '0;
            y_ff   <= elapsed[AGE_SHIFT +: DIV_Y_W];
         end
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         y_ff   <= y_ff >> DIV_CHUNK_W;
         if (count_ff == DIV_CNT_W'(1)) begin
            age_ff <= acc_in[AGE_POS +: AGE_W];
         end
      end
   end

   assign busy = busy_ff;
   assign age  = age_ff;

endmodule

[hdl/orl_datapath.sv]
// Datapath of the ring log: record memory, ring pointers, fill count,
// peek index, age divider and the result register.
// Depends on orl_pkg and orl_age_div.
module orl_datapath
   import orl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  orl_cmd_type         cmd,
   output orl_status_type      status,
   input  logic [1:0]          req_command,
   input  logic [WORD_W-1:0]   req_temperature_bits,
   input  logic [WORD_W-1:0]   req_humidity_bits,
   input  logic [STAMP_W-1:0]  req_now_us,
   input  logic [COUNT_W-1:0]  req_amount,
   output logic                rsp_entry_valid,
   output logic [AGE_W-1:0]    rsp_age_seconds,
   output logic [WORD_W-1:0]   rsp_temp_out,
   output logic [WORD_W-1:0]   rsp_humid_out,
   output logic [COUNT_W-1:0]  rsp_pending_count,
   output logic                rsp_last
);

   logic [ENTRY_W-1:0] log_mem [CAPACITY];

   logic [1:0]         cmd_ff;
   logic [WORD_W-1:0]  temp_req_ff;
   logic [WORD_W-1:0]  humid_req_ff;
   logic [STAMP_W-1:0] now_ff;
   logic [COUNT_W-1:0] amount_ff;

   logic [SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]  read_slot_ff, read_slot_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [BATCH_W-1:0] batch_n_ff, batch_n_in;
   logic [BATCH_W-1:0] idx_ff, idx_in;

   logic [ENTRY_W-1:0] rd_data_ff;
   logic [STAMP_W-1:0] diff_ff;
   logic               nonpos_ff;

   logic               out_entry_valid_ff;
   logic [AGE_W-1:0]   out_age_ff;
   logic [WORD_W-1:0]  out_temp_ff;
   logic [WORD_W-1:0]  out_humid_ff;
   logic [COUNT_W-1:0] out_pending_ff;
   logic               out_last_ff;

   logic [COUNT_W-1:0] take_n;
   logic [BATCH_W-1:0] batch_calc;
   logic               full;
   logic               batch_end;
   logic [SLOT_W-1:0]  rd_addr;
   logic [STAMP_W-1:0] rd_stamp;
   logic               div_busy;
   logic [AGE_W-1:0]   div_age;

   assign take_n     = (amount_ff < fill_ff) ? amount_ff : fill_ff;
   assign batch_calc = (take_n > COUNT_W'(MAX_BATCH)) ? BATCH_W'(MAX_BATCH)
                                                     : take_n[BATCH_W-1:0];
   assign full       = (fill_ff == COUNT_W'(CAPACITY));
   assign batch_end  = ((idx_ff + BATCH_W'(1)) == batch_n_ff);
   assign rd_addr    = read_slot_ff + SLOT_W'(idx_ff);
   assign rd_stamp   = rd_data_ff[ENTRY_W-1 -: STAMP_W];

   always_comb begin
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      fill_in       = fill_ff;
      batch_n_in    = batch_n_ff;
      idx_in        = idx_ff;
      if (cmd.exec) begin
         unique case (cmd_ff)
            CMD_APPEND: begin
               write_slot_in = write_slot_ff + SLOT_W'(1);
               // Full ring: drop the oldest record
               if (full) begin
                  read_slot_in = read_slot_ff + SLOT_W'(1);
               end else begin
                  fill_in = fill_ff + COUNT_W'(1);
               end
            end
            CMD_ADVANCE: begin
               read_slot_in = read_slot_ff + take_n[SLOT_W-1:0];
               fill_in      = fill_ff - take_n;
            end
            CMD_PEEK: begin
               batch_n_in = batch_calc;
               idx_in     = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.next_rec) begin
         idx_in = idx_ff + BATCH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         fill_ff       <= '0;
         batch_n_ff    <= '0;
         idx_ff        <= '0;
      end else begin
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         fill_ff       <= fill_in;
         batch_n_ff    <= batch_n_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff       <= req_command;
         temp_req_ff  <= req_temperature_bits;
         humid_req_ff <= req_humidity_bits;
         now_ff       <= req_now_us;
         amount_ff    <= req_amount;
      end
   end

   // Record memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.exec && cmd_ff == CMD_APPEND) begin
         log_mem[write_slot_ff] <= {now_ff, temp_req_ff, humid_req_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_data_ff <= log_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         diff_ff   <= now_ff - rd_stamp;
         nonpos_ff <= (now_ff <= rd_stamp);
      end
   end

   orl_age_div u_age_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .nonpos  (nonpos_ff),
      .elapsed (diff_ff),
      .busy    (div_busy),
      .age     (div_age)
   );

   always_ff @(posedge clock) begin
      if (cmd.out_rec) begin
         out_entry_valid_ff <= 1'b1;
         out_age_ff         <= div_age;
         out_temp_ff        <= rd_data_ff[2*WORD_W-1 -: WORD_W];
         out_humid_ff       <= rd_data_ff[WORD_W-1:0];
         out_pending_ff     <= fill_ff;
         out_last_ff        <= batch_end;
      end else if (cmd.out_plain) begin
         out_entry_valid_ff <= 1'b0;
         out_age_ff         <= '0;
         out_temp_ff        <= '0;
         out_humid_ff       <= '0;
         out_pending_ff     <= fill_ff;
         out_last_ff        <= 1'b1;
      end
   end

   assign status.op         = cmd_ff;
   assign status.batch_zero = (take_n == '0);
   assign status.div_busy   = div_busy;
   assign status.out_last   = out_last_ff;

   assign rsp_entry_valid   = out_entry_valid_ff;
   assign rsp_age_seconds   = out_age_ff;
   assign rsp_temp_out      = out_temp_ff;
   assign rsp_humid_out     = out_humid_ff;
   assign rsp_pending_count = out_pending_ff;
   assign rsp_last          = out_last_ff;

endmodule

[hdl/orl_ctrl.sv]
// Controller of the ring log: sequences command execution, record reads,
// age division and result transfers. Depends on orl_pkg.
module orl_ctrl
   import orl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  orl_status_type status,
   output orl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_PLAIN,
      S_READ,
      S_DIFF,
      S_DIV_START,
      S_DIV_WAIT,
      S_LOAD,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.exec = 1'b1;
            if (status.op == CMD_PEEK && !status.batch_zero) begin
               state_in = S_READ;
            end else begin
               state_in = S_PLAIN;
            end
         end
         S_PLAIN: begin
            cmd.out_plain = 1'b1;
            state_in      = S_OUT;
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.out_rec = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            // Hold the result until the transfer completes
            if (!rsp_stall) begin
               if (status.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_rec = 1'b1;
                  state_in     = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
         rsp_valid_ff <= (state_in == S_OUT);
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/overwrite_ring_log_with_age_top.sv]
// Ring log top level. Append, advance and unused commands each give one plain
// result. Peek gives one result per record taken; the reciprocal multiply for
// the age sets the time per record, which is shorter when the age is zero or
// saturated. One item in flight at a time.
// Synchronous reset clears ring pointers and fill count at once; the record
// memory is not cleared and needs no clearing pass.
module overwrite_ring_log_with_age_top
   import orl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [WORD_W-1:0]   req_temperature_bits,
   input  logic [WORD_W-1:0]   req_humidity_bits,
   input  logic [STAMP_W-1:0]  req_now_us,
   input  logic [COUNT_W-1:0]  req_amount,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_entry_valid,
   output logic [AGE_W-1:0]    rsp_age_seconds,
   output logic [WORD_W-1:0]   rsp_temp_out,
   output logic [WORD_W-1:0]   rsp_humid_out,
   output logic [COUNT_W-1:0]  rsp_pending_count,
   output logic                rsp_last
);

   orl_cmd_type    cmd;
   orl_status_type status;

   orl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   orl_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_command          (req_command),
      .req_temperature_bits (req_temperature_bits),
      .req_humidity_bits    (req_humidity_bits),
      .req_now_us           (req_now_us),
      .req_amount           (req_amount),
      .rsp_entry_valid      (rsp_entry_valid),
      .rsp_age_seconds      (rsp_age_seconds),
      .rsp_temp_out         (rsp_temp_out),
      .rsp_humid_out        (rsp_humid_out),
      .rsp_pending_count    (rsp_pending_count),
      .rsp_last             (rsp_last)
   );

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pending_count <= COUNT_W'(CAPACITY))
      else $error("pending count above capacity");

   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_valid) |-> (rsp_last && rsp_age_seconds == '0
         && rsp_temp_out == '0 && rsp_humid_out == '0))
      else $error("empty result carries data or is not last");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall)
      else $error("not ready after final result transfer");

endmodule

[verif/overwrite_ring_log_with_age_top_tb.sv]
// Self-checking testbench for overwrite_ring_log_with_age_top: directed table,
// then random commands checked against an in-bench log model.
// Depends on orl_pkg and the top-level RTL only.
module overwrite_ring_log_with_age_top_tb;
   import orl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]         CMD_UNUSED     = 2'd3;
   localparam int                 WATCHDOG_LIMIT = 2000;
   localparam int                 LONG_HOLD      = 300;
   localparam int                 RANDOM_ITEMS   = 128;
   localparam logic [STAMP_W-1:0] STAMP_MAX      = {STAMP_W{1'b1}};

   typedef struct packed {
      logic               entry_valid;
      logic [AGE_W-1:0]   age;
      logic [WORD_W-1:0]  temp;
      logic [WORD_W-1:0]  humid;
      logic [COUNT_W-1:0] pending;
      logic               last;
   } log_rsp_t;

   typedef struct {
      logic [1:0]         command;
      logic [WORD_W-1:0]  temp;
      logic [WORD_W-1:0]  humid;
      logic [STAMP_W-1:0] now_us;
      logic [COUNT_W-1:0] amount;
      bit                 typed;
      log_rsp_t           want;
   } log_cmd_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = CMD_APPEND;
   logic [WORD_W-1:0]  req_temperature_bits = '0;
   logic [WORD_W-1:0]  req_humidity_bits = '0;
   logic [STAMP_W-1:0] req_now_us = '0;
   logic [COUNT_W-1:0] req_amount = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_entry_valid;
   logic [AGE_W-1:0]   rsp_age_seconds;
   logic [WORD_W-1:0]  rsp_temp_out;
   logic [WORD_W-1:0]  rsp_humid_out;
   logic [COUNT_W-1:0] rsp_pending_count;
   logic               rsp_last;

   overwrite_ring_log_with_age_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_temperature_bits (req_temperature_bits),
      .req_humidity_bits    (req_humidity_bits),
      .req_now_us           (req_now_us),
      .req_amount           (req_amount),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_entry_valid      (rsp_entry_valid),
      .rsp_age_seconds      (rsp_age_seconds),
      .rsp_temp_out         (rsp_temp_out),
      .rsp_humid_out        (rsp_humid_out),
      .rsp_pending_count    (rsp_pending_count),
      .rsp_last             (rsp_last)
   );

   always #2 clock = ~clock;

   // Log model state
   logic [STAMP_W-1:0] stamp_mem [CAPACITY];
   logic [WORD_W-1:0]  temp_mem  [CAPACITY];
   logic [WORD_W-1:0]  humid_mem [CAPACITY];
   int unsigned        wr_slot = 0;
   int unsigned        rd_slot = 0;
   int unsigned        fill = 0;

   log_rsp_t predicted [$];
   log_rsp_t awaited_rsp [$];
   log_cmd_t directed_q [$];

   bit       quiet = 1'b0;
   bit       long_hold = 1'b0;
   int       stall_left = 0;
   int       mismatches = 0;
   int       idle_cycles = 0;
   log_rsp_t want_rsp;

   function automatic logic [AGE_W-1:0] age_secs(logic [STAMP_W-1:0] now,
                                                logic [STAMP_W-1:0] stamp);
      logic [63:0] secs;
      if (now <= stamp)
         return '0;
      secs = (64'(now) - 64'(stamp)) / 64'(US_PER_SECOND);
      return (secs > 64'hFFFF_FFFF) ? '1 : secs[AGE_W-1:0];
   endfunction

   // Apply one command to the log model and collect the results it causes
   task automatic predict_ring_log(input log_cmd_t c);
      int unsigned n;
      int unsigned slot;
      log_rsp_t    r;
      predicted.delete();
      r = '0;
      r.last = 1'b1;
      case (c.command)
         CMD_APPEND: begin
            stamp_mem[SLOT_W'(wr_slot)] = c.now_us;
            temp_mem[SLOT_W'(wr_slot)]  = c.temp;
            humid_mem[SLOT_W'(wr_slot)] = c.humid;
            wr_slot = (wr_slot + 1) % CAPACITY;
            if (fill >= CAPACITY)
               rd_slot = (rd_slot + 1) % CAPACITY;
            else
               fill++;
         end
         CMD_PEEK: begin
            n = 32'(c.amount);
            if (n > fill) n = fill;
            if (n > MAX_BATCH) n = MAX_BATCH;
            for (int i = 0; i < n; i++) begin
               slot = (rd_slot + i) % CAPACITY;
               r.entry_valid = 1'b1;
               r.age         = age_secs(c.now_us, stamp_mem[SLOT_W'(slot)]);
               r.temp        = temp_mem[SLOT_W'(slot)];
               r.humid       = humid_mem[SLOT_W'(slot)];
               r.pending     = COUNT_W'(fill);
               r.last        = (i == n - 1);
               predicted.push_back(r);
            end
         end
         CMD_ADVANCE: begin
            n = (32'(c.amount) > fill) ? fill : 32'(c.amount);
            rd_slot = (rd_slot + n) % CAPACITY;
            fill -= n;
         end
         default: ;
      endcase
      if (predicted.size() == 0) begin
         r.pending = COUNT_W'(fill);
         predicted.push_back(r);
      end
   endtask

   function automatic log_rsp_t plain_rsp(int pending);
      log_rsp_t r;
      r = '0;
      r.pending = COUNT_W'(pending);
      r.last = 1'b1;
      return r;
   endfunction

   function automatic log_rsp_t rec_rsp(logic [AGE_W-1:0] age, logic [WORD_W-1:0] t,
                                        logic [WORD_W-1:0] h, int pending);
      log_rsp_t r;
      r = plain_rsp(pending);
      r.entry_valid = 1'b1;
      r.age = age;
      r.temp = t;
      r.humid = h;
      return r;
   endfunction

   task automatic add_row(input logic [1:0] cmd, input logic [WORD_W-1:0] t,
                          input logic [WORD_W-1:0] h, input logic [STAMP_W-1:0] now,
                          input int amt, input bit typed, input log_rsp_t want);
      log_cmd_t c;
      c.command = cmd;
      c.temp    = t;
      c.humid   = h;
      c.now_us  = now;
      c.amount  = COUNT_W'(amt);
      c.typed   = typed;
      c.want    = want;
      directed_q.push_back(c);
   endtask

   // Offer one command, hold it until the transfer, then book its results
   task automatic drive_item(input log_cmd_t c);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_command          <= c.command;
      req_temperature_bits <= c.temp;
      req_humidity_bits    <= c.humid;
      req_now_us           <= c.now_us;
      req_amount           <= c.amount;
      do @(posedge clock); while (req_stall);
      predict_ring_log(c);
      if (c.typed)
         awaited_rsp.push_back(c.want);
      else
         foreach (predicted[k]) awaited_rsp.push_back(predicted[k]);
   endtask

   // Stop offering and wait for every booked result
   task automatic drain_results;
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // Result side: check each transfer, then draw the stall before the next one
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               flag_mismatch("unexpected result, pending_count", 64'(rsp_pending_count),
                             64'(0));
            end else begin
               want_rsp = awaited_rsp.pop_front();
               if (rsp_entry_valid !== want_rsp.entry_valid)
                  flag_mismatch("entry_valid", 64'(rsp_entry_valid),
                                64'(want_rsp.entry_valid));
               if (rsp_age_seconds !== want_rsp.age)
                  flag_mismatch("age_seconds", 64'(rsp_age_seconds), 64'(want_rsp.age));
               if (rsp_temp_out !== want_rsp.temp)
                  flag_mismatch("temp_out", 64'(rsp_temp_out), 64'(want_rsp.temp));
               if (rsp_humid_out !== want_rsp.humid)
                  flag_mismatch("humid_out", 64'(rsp_humid_out), 64'(want_rsp.humid));
               if (rsp_pending_count !== want_rsp.pending)
                  flag_mismatch("pending_count", 64'(rsp_pending_count),
                                64'(want_rsp.pending));
               if (rsp_last !== want_rsp.last)
                  flag_mismatch("last", 64'(rsp_last), 64'(want_rsp.last));
            end
            stall_left = quiet ? 0 : $urandom_range(0, 7);
         end
         if (long_hold) begin
            stall_left = LONG_HOLD;
            long_hold = 1'b0;
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("overwrite_ring_log_with_age_top_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      log_cmd_t           c;
      int                 pick;
      logic [STAMP_W-1:0] wall_us;

      // Extremes, boundaries of the age math, empty log and clamped advances
      add_row(CMD_PEEK, '0, '0, '0, 5, 1, plain_rsp(0));
      add_row(CMD_ADVANCE, '0, '0, '0, CAPACITY, 1, plain_rsp(0));
      add_row(CMD_UNUSED, '1, '1, STAMP_MAX, CAPACITY, 1, plain_rsp(0));
      add_row(CMD_APPEND, 32'hFFFF_FFFF, 32'h0, '0, 0, 1, plain_rsp(1));
      add_row(CMD_APPEND, 32'h0, 32'hFFFF_FFFF, STAMP_MAX, 0, 1, plain_rsp(2));
      add_row(CMD_PEEK, '0, '0, STAMP_MAX, 0, 1, plain_rsp(2));
      add_row(CMD_PEEK, '0, '0, STAMP_MAX, 1, 1, rec_rsp('1, 32'hFFFF_FFFF, 32'h0, 2));
      add_row(CMD_PEEK, '0, '0, '0, CAPACITY, 0, '0);
      add_row(CMD_APPEND, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 63'd1_000_000, 0, 1,
              plain_rsp(3));
      add_row(CMD_PEEK, '0, '0, 63'd1_999_999, 3, 0, '0);
      add_row(CMD_PEEK, '0, '0, 63'd4_294_967_294_999_999, 1, 0, '0);
      add_row(CMD_PEEK, '0, '0, 63'd999_999, 1, 1, rec_rsp('0, 32'hFFFF_FFFF, 32'h0, 3));
      add_row(CMD_PEEK, '0, '0, 63'd4_294_967_296_000_000, 3, 0, '0);
      add_row(CMD_ADVANCE, '0, '0, '0, 1, 1, plain_rsp(2));
      add_row(CMD_ADVANCE, '0, '0, '0, 0, 1, plain_rsp(2));
      add_row(CMD_PEEK, '0, '0, 63'd2_500_000, MAX_BATCH, 0, '0);
      add_row(CMD_ADVANCE, '0, '0, '0, CAPACITY, 1, plain_rsp(0));
      add_row(CMD_PEEK, '0, '0, STAMP_MAX, MAX_BATCH, 1, plain_rsp(0));
      add_row(CMD_UNUSED, 32'h1234_5678, 32'h8765_4321, 63'd12345, 77, 1, plain_rsp(0));
      add_row(CMD_APPEND, 32'h1234_5678, 32'h9ABC_DEF0, 63'd5, 0, 1, plain_rsp(1));
      add_row(CMD_PEEK, '0, '0, 63'd4, 2, 0, '0);
      add_row(CMD_ADVANCE, '0, '0, '0, 2, 1, plain_rsp(0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[k]) drive_item(directed_q[k]);
      drain_results();

      c.typed = 1'b0;
      c.want = '0;
      wall_us = 63'd20_000_000;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= 25 && i < 50) || (i >= 60 && i < 72);
         if (i == 60) long_hold = 1'b1;
         if (i == 110) drain_results();
         wall_us += STAMP_W'($urandom_range(0, 3_000_000));
         c.temp = $urandom;
         c.humid = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 50)
            c.command = CMD_APPEND;
         else if (pick < 75)
            c.command = CMD_PEEK;
         else if (pick < 95)
            c.command = CMD_ADVANCE;
         else
            c.command = CMD_UNUSED;

         pick = $urandom_range(0, 9);
         if (c.command == CMD_APPEND)
            c.now_us = (pick < 8) ? wall_us + STAMP_W'(pick) :
                       (pick == 8) ? STAMP_W'({$urandom, $urandom}) : STAMP_MAX;
         else
            c.now_us = (pick < 6) ? wall_us :
                       (pick < 8) ? STAMP_W'({$urandom, $urandom}) :
                       (pick == 8) ? '0 : STAMP_MAX;

         pick = $urandom_range(0, 99);
         if (c.command == CMD_ADVANCE)
            c.amount = (pick < 90) ? COUNT_W'($urandom_range(0, 3)) :
                       (pick < 95) ? COUNT_W'($urandom_range(4, CAPACITY)) :
                       COUNT_W'(CAPACITY);
         else
            c.amount = (pick < 60) ? COUNT_W'($urandom_range(0, 8)) :
                       (pick < 75) ? COUNT_W'($urandom_range(MAX_BATCH - 4, MAX_BATCH + 6)) :
                       (pick < 85) ? COUNT_W'(CAPACITY) :
                       COUNT_W'($urandom_range(0, CAPACITY));
         drive_item(c);
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && awaited_rsp.size() == 0)
         $display("overwrite_ring_log_with_age_top_tb: done, clean");
      else
         $display("overwrite_ring_log_with_age_top_tb: done, errors");
      $finish;
   end

endmodule
